### rtl/core/naive_substring_matcher_top_defines.svh
// Assertion macros shared by the substring matcher RTL.
// Used by the files under rtl/core that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef NAIVE_SUBSTRING_MATCHER_TOP_DEFINES_SVH
`define NAIVE_SUBSTRING_MATCHER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NSM_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/nsm_pkg.sv
// Package for the substring matcher: default sizes, operation codes and the queued command type.
// Used by the top, front end, queue, back end and testbench; depends on nothing.
package nsm_pkg;

    localparam int PMAX_DEFAULT = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef enum logic [1:0] {
        OP_PAT_BYTE  = 2'd0,
        OP_PAT_END   = 2'd1,
        OP_TEXT_BYTE = 2'd2,
        OP_TEXT_END  = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

### rtl/core/nsm_if.sv
// Handshake channel interfaces for the substring matcher: input items and result items.
// Standalone; no package needed.
interface nsm_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output func, output data_byte, output last, input ready);
    modport sink   (input valid, input func, input data_byte, input last, output ready);
endinterface

interface nsm_out_if;
    logic valid;
    logic ready;
    logic found;
    logic pattern_overflow;

    modport source (output valid, output found, output pattern_overflow, input ready);
    modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

### rtl/core/naive_substring_matcher_top.sv
// Top level of the exact substring matcher: front end, command queue and back end.
// Depends on nsm_pkg, nsm_if, nsm_front, nsm_queue and nsm_back.

// The block searches a text stream for a stored pattern of up to PMAX bytes. Pattern bytes
// (func 0) are loaded one item at a time with last marking the final byte; a pattern byte that
// arrives with no load open starts a new pattern, and bytes past PMAX are dropped and reported
// as overflow. Text bytes (func 1) shift into a PMAX-byte window, and at every text byte the
// newest pattern-length bytes are compared with the pattern in all PMAX byte lanes at once. The
// text item marked last produces exactly one result item, giving whether the pattern occurred
// anywhere in that text and whether the pattern in use was truncated; the text state is then
// cleared, the pattern is kept. An empty pattern matches any text. Text sent while a pattern
// load is still open is searched for the bytes loaded so far. The block takes one item per
// clock cycle, sustained, and while a result waits at the output it keeps taking items until
// the two-entry command queue is full. The result of a last text item passes through the
// command queue, the compare stage and the output register: at the head of the command queue
// its byte lanes are compared against the pattern into the compare stage, and from there the
// lane results are reduced into the output register. The per-cycle rate is set by the window
// compare, which handles one text byte in each cycle over all PMAX lanes unless stalled.
module naive_substring_matcher_top #(
    parameter int PMAX = nsm_pkg::PMAX_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    nsm_in_if.sink    in_ch,
    nsm_out_if.source out_ch
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    nsm_pkg::cmd_t push_cmd;
    nsm_pkg::cmd_t q_cmd;

    // Decodes each input item into a pattern or text command.
    nsm_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    // Lets the input side keep accepting while the back end waits on the output.
    nsm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Holds pattern and window, compares, accumulates matches and drives results.
    nsm_back #(
        .PMAX (PMAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

### rtl/core/nsm_front.sv
// Front end of the substring matcher: takes input items and classifies them into commands.
// Depends on nsm_pkg and nsm_if.
module nsm_front (
    nsm_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          push,
    output nsm_pkg::cmd_t cmd
);

    // An item is taken whenever the command queue has a free slot.
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        cmd.data = in_ch.data_byte;
        unique case ({in_ch.func, in_ch.last})
            {nsm_pkg::FUNC_PATTERN, 1'b0}: cmd.op = nsm_pkg::OP_PAT_BYTE;
            {nsm_pkg::FUNC_PATTERN, 1'b1}: cmd.op = nsm_pkg::OP_PAT_END;
            {nsm_pkg::FUNC_TEXT,    1'b0}: cmd.op = nsm_pkg::OP_TEXT_BYTE;
            {nsm_pkg::FUNC_TEXT,    1'b1}: cmd.op = nsm_pkg::OP_TEXT_END;
        endcase
    end

endmodule

### rtl/core/nsm_queue.sv
// Short command queue between the front end and the back end of the substring matcher.
// Depends on nsm_pkg and the assertion macro header.
`include "naive_substring_matcher_top_defines.svh"

module nsm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nsm_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          q_valid,
    output nsm_pkg::cmd_t q_cmd
);

    localparam int DEPTH = nsm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nsm_pkg::cmd_t    ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `NSM_ASSERT_HOLDS(a_no_push_when_full, push, count_reg != CNT_W'(DEPTH), "push into full queue")
    `NSM_ASSERT_HOLDS(a_no_pop_when_empty, pop, count_reg != '0, "pop from empty queue")
    `NSM_ASSERT_HOLDS(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count above depth")

endmodule

### rtl/core/nsm_back.sv
// Back end of the substring matcher: pattern and text window registers, parallel lane compare,
// match accumulation and the result register. Depends on nsm_pkg, nsm_if and the macro header.
`include "naive_substring_matcher_top_defines.svh"

module nsm_back #(
    parameter int PMAX = nsm_pkg::PMAX_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  nsm_pkg::cmd_t q_cmd,
    output logic          pop,
    nsm_out_if.source     out_ch
);

    localparam int LEN_W = $clog2(PMAX + 1);

    // Pattern is held newest byte first, so lane k always faces text window lane k.
    logic [7:0]       pat_reg [PMAX];
    logic [7:0]       pat_next [PMAX];
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic             popen_reg, popen_next;
    logic             povf_reg, povf_next;

    logic [7:0]       win_reg [PMAX];
    logic [7:0]       win_next [PMAX];
    logic [7:0]       win_shift [PMAX];
    logic [LEN_W-1:0] fill_reg, fill_next, fill_inc;

    logic [LEN_W-1:0] base_len;
    logic             base_ovf;
    logic             is_text, is_last;

    // Compare stage.
    logic             b_valid_reg;
    logic             b_last_reg;
    logic             b_ovf_reg;
    logic             b_cover_reg, b_cover_next;
    logic [PMAX-1:0]  b_eq_reg, b_eq_next;
    logic             b_match;
    logic             seen_reg, seen_next;

    logic             out_valid_reg, out_valid_next;
    logic             found_reg;
    logic             ovf_reg;
    logic             out_stall;
    logic             adv;

    assign out_stall = out_valid_reg && !out_ch.ready;
    assign adv       = !(b_valid_reg && b_last_reg && out_stall);
    assign pop       = q_valid && adv;

    always_comb
    begin
        base_len = popen_reg ? plen_reg : '0;
        base_ovf = popen_reg ? povf_reg : 1'b0;
        fill_inc = (fill_reg < LEN_W'(PMAX)) ? fill_reg + LEN_W'(1) : fill_reg;

        win_shift[0] = q_cmd.data;
        for (int k = 1; k < PMAX; k++)
        begin
            win_shift[k] = win_reg[k-1];
        end

        pat_next   = pat_reg;
        plen_next  = plen_reg;
        popen_next = popen_reg;
        povf_next  = povf_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        is_text    = 1'b0;
        is_last    = 1'b0;

        if (pop)
        begin
            unique case (q_cmd.op) inside
                nsm_pkg::OP_PAT_BYTE, nsm_pkg::OP_PAT_END:
                begin
                    // A byte arriving with no load open starts a fresh pattern.
                    plen_next  = base_len;
                    povf_next  = base_ovf;
                    popen_next = (q_cmd.op == nsm_pkg::OP_PAT_BYTE);
                    if (base_len < LEN_W'(PMAX))
                    begin
                        pat_next[0] = q_cmd.data;
                        for (int k = 1; k < PMAX; k++)
                        begin
                            pat_next[k] = pat_reg[k-1];
                        end
                        plen_next = base_len + LEN_W'(1);
                    end
                    else
                    begin
                        povf_next = 1'b1;
                    end
                end
                nsm_pkg::OP_TEXT_BYTE, nsm_pkg::OP_TEXT_END:
                begin
                    is_text   = 1'b1;
                    is_last   = (q_cmd.op == nsm_pkg::OP_TEXT_END);
                    win_next  = win_shift;
                    // A match needs the fill to cover the pattern length, so clearing the fill clears the text.
                    fill_next = is_last ? '0 : fill_inc;
                end
            endcase
        end
    end

    // Lane compare against the window as it stands after this text byte.
    always_comb
    begin
        for (int k = 0; k < PMAX; k++)
        begin
            b_eq_next[k] = (pat_reg[k] == win_shift[k]) || (LEN_W'(k) >= plen_reg);
        end
        b_cover_next = (fill_inc >= plen_reg);
    end

    assign b_match = b_cover_reg && (&b_eq_reg);

    always_comb
    begin
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (adv && b_valid_reg)
        begin
            seen_next = b_last_reg ? 1'b0 : (seen_reg || b_match);
            if (b_last_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            popen_reg     <= 1'b0;
            povf_reg      <= 1'b0;
            fill_reg      <= '0;
            b_valid_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            popen_reg     <= popen_next;
            povf_reg      <= povf_next;
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                b_valid_reg <= is_text;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
        win_reg <= win_next;
        if (adv)
        begin
            b_last_reg  <= is_last;
            b_ovf_reg   <= povf_reg;
            b_cover_reg <= b_cover_next;
            b_eq_reg    <= b_eq_next;
        end
        if (adv && b_valid_reg && b_last_reg)
        begin
            found_reg <= seen_reg || b_match;
            ovf_reg   <= b_ovf_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.found            = found_reg;
    assign out_ch.pattern_overflow = ovf_reg;

    `NSM_ASSERT_HOLDS(a_len_bound, 1'b1, plen_reg <= LEN_W'(PMAX), "pattern length above PMAX")
    `NSM_ASSERT_HOLDS(a_fill_bound, 1'b1, fill_reg <= LEN_W'(PMAX), "window fill above PMAX")
    `NSM_ASSERT_NEXT(a_stall_holds_result, b_valid_reg && b_last_reg && out_stall,
        b_valid_reg && b_last_reg, "pending result lost under stall")
    `NSM_ASSERT_NEXT(a_text_end_clears, pop && (q_cmd.op == nsm_pkg::OP_TEXT_END),
        fill_reg == '0, "window not cleared after last text byte")

endmodule

### bench/naive_substring_matcher_top_tb.sv
// Self-checking testbench for the exact substring matcher: directed and random pattern/text items.
// Depends on nsm_pkg, the nsm_in_if/nsm_out_if interfaces and naive_substring_matcher_top.
module naive_substring_matcher_top_tb;

    localparam int PMAX         = nsm_pkg::PMAX_DEFAULT;
    // About this many random items follow the directed part.
    localparam int RANDOM_ITEMS = 800;
    // Cycles without any accepted item before the run is declared hung.
    localparam int IDLE_LIMIT   = 4000;
    // Cycles to watch the output after the last verdict for any stray result item.
    localparam int DRAIN_CYCLES = 12;

    // One input item as it travels on the input channel.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    // One search verdict as it travels on the output channel.
    typedef struct packed {
        logic found;
        logic pattern_overflow;
    } verdict_t;

    logic clk;
    logic rst_n;

    nsm_in_if  in_ch();
    nsm_out_if out_ch();

    naive_substring_matcher_top #(
        .PMAX (PMAX)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Items waiting to be sent, filled by the stimulus process and drained by the driver.
    in_item_t   send_q[$];
    // Verdicts the matcher owes, oldest first.
    verdict_t   verdicts[$];
    int         queued_items;
    int         fail_count;
    int         idle_cycles;

    // Our own copy of the matcher state, advanced once per accepted input item.
    logic [7:0] pat_bytes[PMAX];
    int         pat_len;
    bit         pat_loading;
    bit         pat_truncated;
    logic [7:0] win_bytes[PMAX];
    int         win_fill;
    bit         hit_seen;

    // The pattern as the stimulus generator last built it, used to plant matches in text.
    logic [7:0] gen_pat[$];

    // The item currently held on the input channel.
    in_item_t   on_wire;
    int         burst_left;
    int         gap_left;

    logic [15:0] rx_cycle;
    int          rx_hold;

    // Advance the matcher state by one accepted item. A pattern byte that arrives with no
    // load open restarts the pattern; bytes past PMAX only set the truncation flag. A text
    // byte shifts into the window (index 0 newest) and is compared against the pattern,
    // oldest pattern byte against the oldest byte of the newest pattern-length window
    // bytes. An empty pattern therefore matches at every text byte. The text byte marked
    // last owes one verdict and clears the text state, while the pattern stays.
    function automatic void advance_matcher(input in_item_t it);
        bit       hit;
        verdict_t v;
        if (it.func == nsm_pkg::FUNC_PATTERN) begin
            if (!pat_loading) begin
                pat_len       = 0;
                pat_truncated = 1'b0;
                pat_loading   = 1'b1;
            end
            if (pat_len < PMAX) begin
                pat_bytes[pat_len] = it.data_byte;
                pat_len++;
            end else begin
                pat_truncated = 1'b1;
            end
            if (it.last)
                pat_loading = 1'b0;
        end else begin
            for (int k = PMAX - 1; k > 0; k--)
                win_bytes[k] = win_bytes[k - 1];
            win_bytes[0] = it.data_byte;
            if (win_fill < PMAX)
                win_fill++;
            // No match is possible until the window holds at least the pattern length.
            hit = (win_fill >= pat_len);
            for (int j = 0; j < pat_len; j++)
                if (pat_bytes[j] != win_bytes[pat_len - 1 - j])
                    hit = 1'b0;
            if (hit)
                hit_seen = 1'b1;
            if (it.last) begin
                v.found            = hit_seen;
                v.pattern_overflow = pat_truncated;
                verdicts.push_back(v);
                for (int k = 0; k < PMAX; k++)
                    win_bytes[k] = 8'h00;
                win_fill = 0;
                hit_seen = 1'b0;
            end
        end
    endfunction

    task automatic queue_item(input logic f, input logic [7:0] b, input logic l);
        in_item_t it;
        it.func      = f;
        it.data_byte = b;
        it.last      = l;
        send_q.push_back(it);
        queued_items++;
    endtask

    // Narrow characters come from a three-letter alphabet so that random text hits the
    // pattern often; wide ones cover the whole byte range.
    function automatic logic [7:0] pick_char(input bit wide);
        logic [7:0] c;
        if (wide)
            c = 8'($urandom_range(0, 255));
        else
            c = 8'h61 + 8'($urandom_range(0, 2));
        return c;
    endfunction

    task automatic load_pattern(input int n, input bit wide, input bit fresh, input bit close);
        logic [7:0] c;
        if (fresh)
            gen_pat.delete();
        for (int i = 0; i < n; i++) begin
            c = pick_char(wide);
            if (gen_pat.size() < PMAX)
                gen_pat.push_back(c);
            queue_item(nsm_pkg::FUNC_PATTERN, c, close && (i == n - 1));
        end
    endtask

    // Random text of n bytes, optionally with the current pattern planted at a random spot.
    task automatic send_text(input int n, input bit plant, input bit wide, input bit close);
        logic [7:0] txt[$];
        int         at;
        for (int i = 0; i < n; i++)
            txt.push_back(pick_char(wide));
        if (plant && gen_pat.size() > 0 && gen_pat.size() <= n) begin
            at = $urandom_range(0, n - gen_pat.size());
            foreach (gen_pat[j])
                txt[at + j] = gen_pat[j];
        end
        foreach (txt[i])
            queue_item(nsm_pkg::FUNC_TEXT, txt[i], close && (i == n - 1));
    endtask

    // One randomly chosen stretch of stimulus. Most stretches are a full pattern followed
    // by complete texts; the rest exercise texts against the current pattern, long patterns, texts
    // sent while a load is still open, and loose items with random func and last.
    task automatic random_sequence();
        int  kind;
        bit  wide;
        int  texts;
        kind = $urandom_range(0, 9);
        wide = ($urandom_range(0, 3) == 0);
        if (kind <= 5) begin
            load_pattern($urandom_range(1, 6), wide, 1'b1, 1'b1);
            texts = $urandom_range(1, 3);
            for (int t = 0; t < texts; t++)
                send_text($urandom_range(1, 16), 1'($urandom_range(0, 1)),
                          wide && $urandom_range(0, 1), 1'b1);
        end else if (kind == 6) begin
            send_text($urandom_range(1, 24), 1'($urandom_range(0, 1)), wide, 1'b1);
        end else if (kind == 7) begin
            // Around and beyond the full window: exact fit, and truncated loads.
            load_pattern($urandom_range(PMAX - 4, PMAX + 4), wide, 1'b1, 1'b1);
            send_text($urandom_range(PMAX, PMAX + 16), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
        end else if (kind == 8) begin
            load_pattern($urandom_range(1, 3), wide, 1'b1, 1'b0);
            send_text($urandom_range(1, 8), 1'b1, 1'b0, 1'b1);
            load_pattern($urandom_range(1, 3), wide, 1'b0, 1'b1);
            send_text($urandom_range(1, 12), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
        end else begin
            texts = $urandom_range(1, 6);
            for (int t = 0; t < texts; t++)
                queue_item(1'($urandom_range(0, 1)), pick_char(1'b1),
                           1'($urandom_range(0, 1)));
        end
    endtask

    // Block until every queued item has been accepted and every verdict has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (send_q.size() != 0 || in_ch.valid || verdicts.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Input driver. The item on the wire is fed to the predictor at the edge that accepts
    // it. The sender works in bursts of random length separated by random gaps, now and
    // then with a long burst that has no gaps at all. Reset also clears the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.func      <= nsm_pkg::FUNC_PATTERN;
            in_ch.data_byte <= 8'h00;
            in_ch.last      <= 1'b0;
            burst_left      = 1;
            gap_left        = 0;
            pat_len         = 0;
            pat_loading     = 1'b0;
            pat_truncated   = 1'b0;
            win_fill        = 0;
            hit_seen        = 1'b0;
            for (int k = 0; k < PMAX; k++) begin
                pat_bytes[k] = 8'h00;
                win_bytes[k] = 8'h00;
            end
        end else begin
            if (in_ch.valid && in_ch.ready)
                advance_matcher(on_wire);
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    on_wire          = send_q.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.func      <= on_wire.func;
                    in_ch.data_byte <= on_wire.data_byte;
                    in_ch.last      <= on_wire.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 5) == 0)
                            burst_left = 200;
                        else
                            burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver. Every accepted result is checked against the oldest
    // owed verdict. Ready follows a pattern that cycles through four phases: always
    // ready, coin-flip ready, occasional long stalls, and a fixed one-in-four stall.
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        verdict_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            rx_cycle     <= 16'd0;
            rx_hold      <= 0;
            fail_count   = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdicts.size() == 0) begin
                    $error("result item arrived with no verdict owed");
                    fail_count = fail_count + 1;
                end else begin
                    want = verdicts.pop_front();
                    if (out_ch.found !== want.found) begin
                        $error("found: expected %0b, actual %0b", want.found, out_ch.found);
                        fail_count = fail_count + 1;
                    end
                    if (out_ch.pattern_overflow !== want.pattern_overflow) begin
                        $error("pattern_overflow: expected %0b, actual %0b",
                               want.pattern_overflow, out_ch.pattern_overflow);
                        fail_count = fail_count + 1;
                    end
                end
            end
            rx_cycle <= rx_cycle + 16'd1;
            if (rx_hold != 0) begin
                rx_hold      <= rx_hold - 1;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_cycle[9:8])
                    2'd0: out_ch.ready <= 1'b1;
                    2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2'd2:
                    begin
                        if ($urandom_range(0, 7) == 0) begin
                            rx_hold      <= $urandom_range(3, 23);
                            out_ch.ready <= 1'b0;
                        end else begin
                            out_ch.ready <= 1'b1;
                        end
                    end
                    default: out_ch.ready <= (rx_cycle[1:0] != 2'd3);
                endcase
            end
        end
    end

    // Watchdog: a long run of cycles in which neither side accepts anything means a hang.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        queued_items = 0;
        // Asserting reset through a nonblocking update lets the clocked blocks above see
        // the falling edge at time zero, so every input is known from the start.
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Right after reset the pattern is empty, so any text is a hit.
        queue_item(nsm_pkg::FUNC_TEXT, 8'h00, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'hFF, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h5A, 1'b1);
        // Extreme byte values as a two-byte pattern, matched and then reversed.
        queue_item(nsm_pkg::FUNC_PATTERN, 8'h00, 1'b0);
        queue_item(nsm_pkg::FUNC_PATTERN, 8'hFF, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h00, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'hFF, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'hFF, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h00, 1'b1);
        // Text shorter than the pattern cannot match.
        queue_item(nsm_pkg::FUNC_TEXT, 8'h00, 1'b1);
        // Text while a load is still open uses the bytes loaded so far, then the load
        // goes on and the longer pattern is searched.
        queue_item(nsm_pkg::FUNC_PATTERN, 8'h61, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h61, 1'b1);
        queue_item(nsm_pkg::FUNC_PATTERN, 8'h62, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h78, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h61, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h62, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h79, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h62, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h61, 1'b1);
        // A closed pattern followed by a pattern byte starts over; a match on the final
        // text byte counts, and a hit earlier in the text survives later misses.
        queue_item(nsm_pkg::FUNC_PATTERN, 8'h71, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h71, 1'b1);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h71, 1'b0);
        queue_item(nsm_pkg::FUNC_TEXT, 8'h72, 1'b1);
        // Hold the sender until every verdict so far is back.
        wait_drained();

        // A truncated pattern first, so that overflow is seen early, then random stretches.
        load_pattern(PMAX + 2, 1'b0, 1'b1, 1'b1);
        send_text(PMAX + 6, 1'b1, 1'b0, 1'b1);
        while (queued_items < RANDOM_ITEMS / 2)
            random_sequence();
        send_text(1, 1'b0, 1'b1, 1'b1);
        wait_drained();

        while (queued_items < RANDOM_ITEMS + 24)
            random_sequence();
        send_text(1, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // Watch a little longer for any stray result item.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### naive_substring_matcher_top.f
+incdir+rtl/core
rtl/core/nsm_pkg.sv
rtl/core/nsm_if.sv
rtl/core/nsm_front.sv
rtl/core/nsm_queue.sv
rtl/core/nsm_back.sv
rtl/core/naive_substring_matcher_top.sv
bench/naive_substring_matcher_top_tb.sv
